[rtl/core/trapezoidal_velocity_ramp_assert.svh]
// assertion helpers for the checker file trv_checker.sv
`ifndef TRAPEZOIDAL_VELOCITY_RAMP_ASSERT_SVH
`define TRAPEZOIDAL_VELOCITY_RAMP_ASSERT_SVH

// checked on every clock edge outside reset
`define TRV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define TRV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/trv_pkg.sv]
package trv_pkg;

  // field and register widths
  localparam int POS_W  = 48;
  localparam int VEL_W  = 32;
  localparam int ACC_W  = 31;
  localparam int BAND_W = 32;
  localparam int CMD_W  = 2;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;

  // split of the error magnitude for the two partial products
  localparam int LO_W   = POS_W / 2;
  localparam int HI_W   = POS_W - LO_W;
  localparam int PROD_W = POS_W + ACC_W;
  localparam int VSQ_W  = 2 * ACC_W;

  // queue depths
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // saturation limits of the position
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // register reset values
  localparam logic [ACC_W-1:0]  ACCEL_RST = 31'd386547;
  localparam logic [ACC_W-1:0]  VMAX_RST  = 31'd343597384;
  localparam logic [BAND_W-1:0] BAND_RST  = 32'd429497;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ACCEL_STEP   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_VELOCITY = 2'd1;
  localparam logic [IDX_W-1:0] REG_SETTLE_BAND  = 2'd2;

  // command codes on the input port
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYNC = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_SYNC,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_UPD
  } st_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
    logic             decel;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } rq_wr_t;

endpackage

[rtl/core/trv_front.sv]
module trv_front
  import trv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic        [CMD_W-1:0] command,
  input  logic signed [POS_W-1:0] position_value,
  input  logic                    take,
  output cmd_t                    cmd
);

  item_t               mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;
  item_t               item_in;

  // classify the incoming command
  always_comb begin
    item_in.pos = position_value;
    case (command)
      CMD_TICK: item_in.op = OP_TICK;
      CMD_SET:  item_in.op = OP_SET;
      CMD_SYNC: item_in.op = OP_SYNC;
      default:  item_in.op = OP_NOP;
    endcase
  end

  assign full    = (count == FQ_CNT_W'(FQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = take && (count != '0);

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // head of queue towards the back end
  always_comb begin
    cmd.valid = (count != '0);
    cmd.op    = mem[rd_ptr].op;
    cmd.pos   = mem[rd_ptr].pos;
  end

endmodule

[rtl/core/trv_back.sv]
module trv_back
  import trv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output logic             take,
  input  logic             rq_full,
  output rq_wr_t           wr
);

  // configuration
  logic [ACC_W-1:0]  accel;
  logic [ACC_W-1:0]  vmax;
  logic [BAND_W-1:0] band;

  // ramp state
  st_t              state;
  st_t              state_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] tgt;
  logic [POS_W-1:0] tgt_next;
  logic [VEL_W-1:0] vel;
  logic [VEL_W-1:0] vel_next;
  logic             last_decel;
  logic             last_decel_next;

  // first step: error and velocity magnitude
  logic [POS_W:0]   diff;
  logic [POS_W:0]   diff_neg;
  logic [VEL_W-1:0] vel_neg;
  logic [POS_W-1:0] emag;
  logic             e_pos;
  logic             e_neg;
  logic [ACC_W-1:0] vmag;
  logic             v_neg;
  logic             v_pos;

  // second step: products and velocity candidates
  logic [HI_W+ACC_W-1:0] p_hi;
  logic [LO_W+ACC_W-1:0] p_lo;
  logic [VSQ_W-1:0]      vsq;
  logic [ACC_W-1:0]      dmag;
  logic signed [VEL_W:0] v_acc;
  logic                  far;
  logic signed [VEL_W:0] ext_v;
  logic signed [VEL_W:0] ext_a;

  // third step: decision and clamp
  logic [PROD_W-1:0]     prod;
  logic                  in_reach;
  logic                  decel_d;
  logic [ACC_W-1:0]      dmag_c;
  logic [VEL_W-1:0]      dmag_ext;
  logic [VEL_W-1:0]      v_dec;
  logic signed [VEL_W:0] vmax_p;
  logic signed [VEL_W:0] vmax_n;
  logic [VEL_W-1:0]      v_acc_c;
  logic [VEL_W-1:0]      v_new_d;
  logic [VEL_W-1:0]      v_new;
  logic                  decel;

  // last step: position integration
  logic [POS_W:0]   sum;
  logic [POS_W-1:0] pos_sat;
  logic             move;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= ACCEL_RST;
      vmax  <= VMAX_RST;
      band  <= BAND_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACCEL_STEP:   accel <= cfg_data[ACC_W-1:0];
        REG_MAX_VELOCITY: vmax  <= cfg_data[ACC_W-1:0];
        REG_SETTLE_BAND:  band  <= cfg_data[BAND_W-1:0];
        default:          ;
      endcase
    end
  end

  // error from target and velocity magnitude
  always_comb begin
    diff     = {tgt[POS_W-1], tgt} - {pos[POS_W-1], pos};
    diff_neg = ~diff + 1'b1;
    vel_neg  = ~vel + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      emag  <= diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];
      e_neg <= diff[POS_W];
      e_pos <= !diff[POS_W] && (diff != '0);
      vmag  <= vel[VEL_W-1] ? vel_neg[ACC_W-1:0] : vel[ACC_W-1:0];
      v_neg <= vel[VEL_W-1];
      v_pos <= !vel[VEL_W-1] && (vel != '0);
    end
  end

  // partial products of error times step, velocity squared
  assign ext_v = signed'({vel[VEL_W-1], vel});
  assign ext_a = signed'({2'b00, accel});

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      p_hi  <= (HI_W+ACC_W)'(emag[POS_W-1:LO_W]) * (HI_W+ACC_W)'(accel);
      p_lo  <= (LO_W+ACC_W)'(emag[LO_W-1:0]) * (LO_W+ACC_W)'(accel);
      vsq   <= VSQ_W'(vmag) * VSQ_W'(vmag);
      dmag  <= (vmag > accel) ? vmag - accel : '0;
      v_acc <= e_pos ? ext_v + ext_a : ext_v - ext_a;
      far   <= emag > POS_W'(band);
    end
  end

  // stop-distance test and velocity selection
  always_comb begin
    prod     = {p_hi, {LO_W{1'b0}}} + PROD_W'(p_lo);
    in_reach = {prod, 1'b0} <= (PROD_W+1)'(vsq);
    decel_d  = in_reach && !((e_pos && v_neg) || (e_neg && v_pos));
    dmag_c   = (dmag > vmax) ? vmax : dmag;
    dmag_ext = {1'b0, dmag_c};
    v_dec    = v_neg ? ~dmag_ext + 1'b1 : dmag_ext;
    vmax_p   = signed'({2'b00, vmax});
    vmax_n   = -vmax_p;
    if (v_acc > vmax_p) begin
      v_acc_c = vmax_p[VEL_W-1:0];
    end else if (v_acc < vmax_n) begin
      v_acc_c = vmax_n[VEL_W-1:0];
    end else begin
      v_acc_c = v_acc[VEL_W-1:0];
    end
    v_new_d = decel_d ? v_dec : v_acc_c;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      v_new <= v_new_d;
      decel <= decel_d;
    end
  end

  // saturating position integration
  always_comb begin
    sum     = {pos[POS_W-1], pos} + {{(POS_W+1-VEL_W){v_new[VEL_W-1]}}, v_new};
    pos_sat = (sum[POS_W] != sum[POS_W-1]) ? (sum[POS_W] ? POS_MIN : POS_MAX)
                                           : sum[POS_W-1:0];
    move    = (v_new != '0) || far;
  end

  // sequencer state and ramp state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      tgt        <= '0;
      vel        <= '0;
      last_decel <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      tgt        <= tgt_next;
      vel        <= vel_next;
      last_decel <= last_decel_next;
    end
  end

  // sequencer: set, sync and unused commands answered from idle, four-step tick
  always_comb begin
    state_next      = state;
    take            = 1'b0;
    wr.push         = 1'b0;
    pos_next        = pos;
    tgt_next        = tgt;
    vel_next        = vel;
    last_decel_next = last_decel;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.op == OP_TICK) begin
            take       = 1'b1;
            state_next = ST_MUL;
          end else if (!rq_full) begin
            take    = 1'b1;
            wr.push = 1'b1;
            case (cmd.op)
              OP_SET: tgt_next = cmd.pos;
              OP_SYNC: begin
                pos_next = cmd.pos;
                tgt_next = cmd.pos;
              end
              default: ;
            endcase
          end
        end
      end
      ST_MUL: state_next = ST_CMP;
      ST_CMP: state_next = ST_UPD;
      ST_UPD: begin
        if (!rq_full) begin
          wr.push         = 1'b1;
          vel_next        = v_new;
          last_decel_next = decel;
          if (move) begin
            pos_next = pos_sat;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    wr.res.pos   = pos_next;
    wr.res.vel   = vel_next;
    wr.res.decel = last_decel_next;
  end

endmodule

[rtl/core/trv_result_q.sv]
module trv_result_q
  import trv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  rq_wr_t wr,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output res_t   head
);

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == RQ_CNT_W'(RQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr.res;
    end
  end

endmodule

[rtl/core/trapezoidal_velocity_ramp.sv]
// the back end takes one command at a time and runs a tick through a four-step sequence
// (error, multiply, compare, integrate) before taking the next; set, sync and unused
// commands are answered straight from idle; both wait while the result queue is full
// a 4-entry command queue and a 2-entry result queue let both sides stall on their own
// reset (rst, synchronous): queues empty, position, target, velocity and flag cleared,
// registers back to their default values
module trapezoidal_velocity_ramp
  import trv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic        [IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0] cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic        [CMD_W-1:0] command,
  input  logic signed [POS_W-1:0] position_value,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [POS_W-1:0] position_command,
  output logic signed [VEL_W-1:0] velocity,
  output logic                    decelerating
);

  cmd_t   cmd;
  logic   take;
  logic   rq_full;
  rq_wr_t wr;
  res_t   head;

  // command intake and classification
  trv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .position_value (position_value),
    .take           (take),
    .cmd            (cmd)
  );

  // ramp arithmetic and state
  trv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .take      (take),
    .rq_full   (rq_full),
    .wr        (wr)
  );

  // result queue
  trv_result_q u_rq (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .full  (rq_full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign position_command = head.pos;
  assign velocity         = head.vel;
  assign decelerating     = head.decel;

endmodule

[rtl/core/trv_checker.sv]
`include "trapezoidal_velocity_ramp_assert.svh"

module trv_checker
  import trv_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic signed [POS_W-1:0] position_command,
  input logic signed [VEL_W-1:0] velocity,
  input logic                    decelerating
);

  localparam logic signed [VEL_W-1:0] VEL_MOST_NEG = {1'b1, {(VEL_W-1){1'b0}}};

  logic                   waiting;
  logic [POS_W+VEL_W:0]   held;

  // result on offer but not taken, and the fields it shows
  assign waiting = !empty && !pop;
  assign held    = {position_command, velocity, decelerating};

  // reset leaves both queues open and empty
  `TRV_ASSERT_ALWAYS(a_reset_clear, rst |=> (empty && !full), "queues not clear after reset")

  // a waiting result holds until it is taken
  `TRV_ASSERT(a_result_hold, waiting |=> (!empty && $stable(held)), "waiting result changed")

  // velocity stays inside the symmetric clamp range
  `TRV_ASSERT(a_vel_range, !empty |-> (velocity != VEL_MOST_NEG), "velocity outside clamp range")

endmodule

bind trapezoidal_velocity_ramp trv_checker u_chk (.*);

[tb/sv/ramp_checker.sv]
`timescale 1ns / 1ps

// watches the command, result and register ports of the velocity ramp,
// predicts each result and compares it field by field
module ramp_checker
  import trv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic        [IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0] cfg_data,
  input  logic                    push,
  input  logic                    full,
  input  logic        [CMD_W-1:0] command,
  input  logic signed [POS_W-1:0] position_value,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [POS_W-1:0] position_command,
  input  logic signed [VEL_W-1:0] velocity,
  input  logic                    decelerating,
  output int                      mismatch_count,
  output int                      backlog
);

  localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;

  // own copy of the ramp state and registers
  logic signed [POS_W-1:0] ramp_pos;
  logic signed [POS_W-1:0] goal_pos;
  longint                  ramp_vel;
  logic                    braking;
  longint unsigned         accel_reg;
  longint unsigned         vmax_reg;
  longint unsigned         band_reg;

  // results still owed by the block, oldest first
  res_t owed_results[$];

  initial begin
    mismatch_count = 0;
    backlog = 0;
  end

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // one control period of the trapezoidal ramp
  task automatic advance_ramp();
    longint          p;
    longint          t;
    longint          v;
    longint          a;
    longint          vm;
    longint unsigned err_mag;
    longint unsigned vel_mag;
    int              err_sign;
    logic [127:0]    stop_lhs;
    logic [127:0]    stop_rhs;
    bit              near_stop;
    p  = longint'(ramp_pos);
    t  = longint'(goal_pos);
    v  = ramp_vel;
    a  = longint'(accel_reg);
    vm = longint'(vmax_reg);

    // error magnitude and direction
    if (t >= p) begin
      err_mag  = t - p;
      err_sign = (err_mag != 0) ? 1 : 0;
    end else begin
      err_mag  = p - t;
      err_sign = -1;
    end

    // stopping test without a division: |e| * 2a <= v^2, exact width
    vel_mag   = (v < 0) ? -v : v;
    stop_lhs  = 128'(err_mag) * 128'(2 * accel_reg);
    stop_rhs  = 128'(vel_mag) * 128'(vel_mag);
    near_stop = (stop_lhs <= stop_rhs);

    if (near_stop && !((err_sign > 0 && v < 0) || (err_sign < 0 && v > 0))) begin
      braking = 1'b1;
      if (v > 0)
        v = (v > a) ? v - a : 0;
      else if (v < 0)
        v = (-v > a) ? v + a : 0;
    end else begin
      braking = 1'b0;
      v = (err_sign > 0) ? v + a : v - a;
    end

    // velocity limit
    if (v > vm)
      v = vm;
    else if (v < -vm)
      v = -vm;
    ramp_vel = v;

    // integrate with saturation, hold while settled
    if (v != 0 || err_mag > band_reg) begin
      if (v > 0 && p > POS_HI - v)
        p = POS_HI;
      else if (v < 0 && p < POS_LO - v)
        p = POS_LO;
      else
        p = p + v;
    end
    ramp_pos = p[POS_W-1:0];
  endtask

  function automatic res_t ramp_outputs();
    res_t r;
    r.pos   = ramp_pos;
    r.vel   = ramp_vel[VEL_W-1:0];
    r.decel = braking;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      ramp_pos  = '0;
      goal_pos  = '0;
      ramp_vel  = 0;
      braking   = 1'b0;
      accel_reg = 64'(ACCEL_RST);
      vmax_reg  = 64'(VMAX_RST);
      band_reg  = 64'(BAND_RST);
      owed_results.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_ACCEL_STEP:   accel_reg = 64'(cfg_data[ACC_W-1:0]);
          REG_MAX_VELOCITY: vmax_reg  = 64'(cfg_data[ACC_W-1:0]);
          REG_SETTLE_BAND:  band_reg  = 64'(cfg_data[BAND_W-1:0]);
          default: ;
        endcase
      end

      // result transaction against the oldest prediction
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: no result expected, got position 0x%0h velocity 0x%0h flag %0b",
                   $time, position_command, velocity, decelerating);
        end else begin
          want = owed_results.pop_front();
          if (position_command !== want.pos)
            flag("position_command", 64'(want.pos), 64'(position_command));
          if (velocity !== want.vel)
            flag("velocity", 64'(want.vel), 64'(velocity));
          if (decelerating !== want.decel)
            flag("decelerating", 64'(want.decel), 64'(decelerating));
        end
      end

      // command transaction: apply and note the result it owes
      if (push && !full) begin
        case (command)
          CMD_TICK: advance_ramp();
          CMD_SET:  goal_pos = position_value;
          CMD_SYNC: begin
            ramp_pos = position_value;
            goal_pos = position_value;
          end
          default: ;
        endcase
        owed_results.push_back(ramp_outputs());
      end
    end
    backlog = owed_results.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import trv_pkg::*;

  localparam int ITEM_TOTAL = 1650;
  localparam int PHASES     = 8;
  localparam int HOLD_TICKS = 300;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ACC_W-1:0] ACC_TOP    = {ACC_W{1'b1}};
  localparam logic [BAND_W-1:0] BAND_TOP  = {BAND_W{1'b1}};

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic        [IDX_W-1:0] cfg_index;
  logic        [CFG_W-1:0] cfg_data;
  logic                    push;
  logic                    full;
  logic        [CMD_W-1:0] command;
  logic signed [POS_W-1:0] position_value;
  logic                    empty;
  logic                    pop;
  logic signed [POS_W-1:0] position_command;
  logic signed [VEL_W-1:0] velocity;
  logic                    decelerating;

  int               mismatches;
  int               backlog;
  int               items_sent;
  bit               no_gaps;
  bit               hold_req;
  logic [ACC_W-1:0] cur_accel;
  logic [ACC_W-1:0] cur_vmax;

  trapezoidal_velocity_ramp u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .command          (command),
    .position_value   (position_value),
    .empty            (empty),
    .pop              (pop),
    .position_command (position_command),
    .velocity         (velocity),
    .decelerating     (decelerating)
  );

  ramp_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .command          (command),
    .position_value   (position_value),
    .empty            (empty),
    .pop              (pop),
    .position_command (position_command),
    .velocity         (velocity),
    .decelerating     (decelerating),
    .mismatch_count   (mismatches),
    .backlog          (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] noisy_value();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return '1;
      default: return rand_pos();
    endcase
  endfunction

  // spread over all magnitudes, never zero
  function automatic logic [ACC_W-1:0] rand_mag();
    logic [ACC_W-1:0] v;
    v = ACC_W'($urandom() >> $urandom_range(1, 31));
    return (v == '0) ? ACC_W'(1) : v;
  endfunction

  task automatic pause_push(int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // one command transaction, waits for the block to take it
  task automatic offer(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] value);
    if (!no_gaps)
      pause_push(pick_gap());
    @(negedge clk);
    push           <= 1'b1;
    command        <= cmd;
    position_value <= value;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // stop sending and let every owed result come back
  task automatic drain();
    pause_push(1);
    while (backlog != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic configure(logic [ACC_W-1:0] accel, logic [ACC_W-1:0] vmax,
                           logic [BAND_W-1:0] band);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ACCEL_STEP;
    cfg_data  <= CFG_W'(accel);
    @(negedge clk);
    cfg_index <= REG_MAX_VELOCITY;
    cfg_data  <= CFG_W'(vmax);
    @(negedge clk);
    cfg_index <= REG_SETTLE_BAND;
    cfg_data  <= band;
    // the unused index last, so an alias would clobber a live register
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom();
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_accel = accel;
    cur_vmax  = vmax;
  endtask

  // a point-to-point move sized to the current limits, or a burst of noise
  task automatic run_sequence();
    int                      kind;
    int                      n;
    longint unsigned         span;
    longint unsigned         alt;
    logic signed [POS_W-1:0] origin;
    logic signed [POS_W-1:0] goal;
    kind    = $urandom_range(0, 9);
    no_gaps = ($urandom_range(0, 4) == 0);
    if (kind < 2) begin
      n = $urandom_range(4, 16);
      repeat (n) offer(CMD_W'($urandom_range(0, 3)), noisy_value());
    end else begin
      span = longint'(cur_accel) * $urandom_range(0, 300);
      alt  = longint'(cur_vmax) * $urandom_range(0, 40);
      if (alt < span)
        span = alt;
      span   = span + $urandom_range(0, 3);
      origin = $signed(rand_pos()) >>> 2;
      goal   = $urandom_range(0, 1) ? origin + POS_W'(span) : origin - POS_W'(span);
      // occasionally start from wherever the ramp already is
      if (kind != 2)
        offer(CMD_SYNC, origin);
      offer(CMD_SET, goal);
      n = $urandom_range(10, 70);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 39))
          0: offer(CMD_SET, origin);
          1: offer(CMD_SYNC, POS_MAX - POS_W'($urandom_range(0, 1000)));
          2: offer(CMD_SYNC, POS_MIN + POS_W'($urandom_range(0, 1000)));
          default: ;
        endcase
        offer(CMD_TICK, rand_pos());
      end
    end
    no_gaps = 1'b0;
  endtask

  // result side: random stalls, steady runs, and one long hold-off
  initial begin
    int stall;
    int steady_left;
    bit hold_done;
    pop = 1'b0;
    steady_left = 0;
    hold_done = 1'b0;
    forever begin
      stall = 0;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall = HOLD_TICKS;
      end else if (steady_left > 0) begin
        steady_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        steady_left = $urandom_range(10, 40);
      end else begin
        stall = pick_gap();
      end
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // command side and verdict
  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_ACCEL_STEP;
    cfg_data       = '0;
    push           = 1'b0;
    command        = CMD_TICK;
    position_value = '0;
    items_sent     = 0;
    no_gaps        = 1'b0;
    hold_req       = 1'b0;
    cur_accel      = ACCEL_RST;
    cur_vmax       = VMAX_RST;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: idle tick at rest, unused command, saturation at both ends
    offer(CMD_TICK, '0);
    offer(CMD_UNUSED, '1);
    offer(CMD_SET, POS_MAX);
    repeat (4) offer(CMD_TICK, '0);
    offer(CMD_SYNC, POS_MAX - POS_W'(5));
    // zero error while moving: braking, then overshoot clamps at the top
    repeat (2) offer(CMD_TICK, '1);
    offer(CMD_SET, POS_MIN);
    repeat (6) offer(CMD_TICK, '0);
    offer(CMD_SYNC, POS_MIN + POS_W'(5));
    offer(CMD_TICK, '0);
    offer(CMD_SYNC, '0);
    offer(CMD_SET, '0);
    repeat (3) offer(CMD_TICK, '0);
    offer(CMD_UNUSED, '0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: configure(ACC_W'(1), ACC_TOP, '0);
        2: configure(ACC_TOP, ACC_W'(1), BAND_TOP);
        3: configure(ACC_TOP, ACC_TOP, $urandom());
        4: configure(ACC_W'(1), ACC_W'(1), $urandom_range(0, 16));
        default: configure(rand_mag(), rand_mag(), $urandom() >> $urandom_range(0, 31));
      endcase
      if (ph == 3)
        hold_req = 1'b1;
      while (items_sent < ITEM_TOTAL * (ph + 1) / PHASES)
        run_sequence();
    end

    pause_push(1);
    while (backlog != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
